@@ hdl/afl_pkg.sv @@
`timescale 1ns / 1ps

package afl_pkg;

    // Sample width modes
    localparam logic [1:0] MODE_8BIT   = 2'd0;
    localparam logic [1:0] MODE_16BIT  = 2'd1;
    localparam logic [1:0] MODE_32BIT  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic REG_WIDTH_MODE = 1'b0;
    localparam logic REG_FRAMES     = 1'b1;

    localparam int SAMPLE_W  = 32;
    localparam int MAG_W     = 32;
    localparam int CFG_W     = 8;
    localparam int MODE_W    = 2;
    localparam int LEVEL_W   = 18;
    localparam int REPORT_W  = 17;
    localparam int LSUM_W    = 27;
    localparam int FCNT_W    = 8;
    localparam int DIVISOR_W = 32;
    localparam int MEAN_W    = 32;

    // Mean is scaled by 2 * 65536 before the full-scale divide
    localparam int LEVEL_SHIFT = 17;
    localparam int SCALED_W    = MEAN_W + LEVEL_SHIFT;

    localparam logic [REPORT_W-1:0] LEVEL_ONE = 17'd65536;

    localparam logic [MODE_W-1:0] RESET_MODE   = MODE_16BIT;
    localparam logic [CFG_W-1:0]  RESET_FRAMES = 8'd3;

    function automatic logic [DIVISOR_W-1:0] full_scale(input logic [MODE_W-1:0] mode);
        logic [DIVISOR_W-1:0] fs;
        case (mode)
            MODE_8BIT:  fs = 32'd127;
            MODE_16BIT: fs = 32'd32767;
            default:    fs = 32'h7FFF_FFFF;
        endcase
        return fs;
    endfunction

endpackage

@@ hdl/audio_frame_level_meter.sv @@
`timescale 1ns / 1ps
// A sample without the frame mark is absorbed in its transfer cycle.
// A frame-end sample runs up to three divisions on one shared bit-serial divider of
// DIV_W bits (49 at the default), then the sequencing states; the report division
// runs only when a report is due, and unused mode skips the level division.
// A frame-end sample holds the input stall high until the result is registered.
// Reset: asynchronous active low; clears sums, counts, control and loads register defaults.
module audio_frame_level_meter
#(
    parameter int MAX_FRAME_SAMPLES = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [afl_pkg::CFG_W-1:0]     cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [afl_pkg::SAMPLE_W-1:0] sample,
    input  logic                          last_in_frame,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [afl_pkg::LEVEL_W-1:0]   frame_level,
    output logic                          report_valid,
    output logic [afl_pkg::REPORT_W-1:0]  report_level
);

    // Sample count must hold MAX_FRAME_SAMPLES itself; the sum can never wrap
    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W = afl_pkg::MAG_W + CNT_W;
    localparam int DIV_W = (SUM_W > afl_pkg::SCALED_W) ? SUM_W : afl_pkg::SCALED_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_MEAN       = 3'd1;
    localparam logic [2:0] ST_MEAN_WAIT  = 3'd2;
    localparam logic [2:0] ST_LEVEL_WAIT = 3'd3;
    localparam logic [2:0] ST_ACCUM      = 3'd4;
    localparam logic [2:0] ST_CHECK      = 3'd5;
    localparam logic [2:0] ST_REP_WAIT   = 3'd6;
    localparam logic [2:0] ST_OUT        = 3'd7;

    logic [2:0] state_reg, state_next;

    // Configuration
    logic [afl_pkg::MODE_W-1:0] mode_reg;
    logic [afl_pkg::CFG_W-1:0]  frames_reg;

    // Accumulators
    logic [SUM_W-1:0]            abs_sum_reg, abs_sum_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [afl_pkg::LSUM_W-1:0]  level_sum_reg, level_sum_next;
    logic [afl_pkg::FCNT_W-1:0]  frame_count_reg, frame_count_next;

    // Per-frame working values
    logic [afl_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic                         rep_valid_reg, rep_valid_next;
    logic [afl_pkg::REPORT_W-1:0] rep_level_reg, rep_level_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [afl_pkg::LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic                         out_rep_valid_reg, out_rep_valid_next;
    logic [afl_pkg::REPORT_W-1:0] out_rep_level_reg, out_rep_level_next;

    // Shared divider
    logic                          div_start;
    logic [DIV_W-1:0]              div_dividend;
    logic [afl_pkg::DIVISOR_W-1:0] div_divisor;
    logic                          div_done;
    logic [DIV_W-1:0]              div_quo;

    logic [afl_pkg::MAG_W-1:0]  mag;
    logic [afl_pkg::MEAN_W-1:0] mean;
    logic [afl_pkg::CFG_W-1:0]  frames_eff;
    logic                       in_xfer;
    logic                       out_free;

    afl_mag u_mag
    (
        .sample    (sample),
        .mode      (mode_reg),
        .magnitude (mag)
    );

    afl_div #(.DIVIDEND_W(DIV_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    // The output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // Mean of magnitudes never exceeds 2^31, so the low 32 quotient bits hold it
    assign mean = div_quo[afl_pkg::MEAN_W-1:0];

    // A report length of zero behaves as one
    assign frames_eff = (frames_reg == '0) ? afl_pkg::CFG_W'(1) : frames_reg;

    always_comb
    begin
        state_next         = state_reg;
        abs_sum_next       = abs_sum_reg;
        count_next         = count_reg;
        level_sum_next     = level_sum_reg;
        frame_count_next   = frame_count_reg;
        level_next         = level_reg;
        rep_valid_next     = rep_valid_reg;
        rep_level_next     = rep_level_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_level_next     = out_level_reg;
        out_rep_valid_next = out_rep_valid_reg;
        out_rep_level_next = out_rep_level_reg;
        div_start          = 1'b0;
        div_dividend       = '0;
        div_divisor        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Drop samples past the frame limit; the frame mark still ends the frame
                    if (count_reg < CNT_W'(MAX_FRAME_SAMPLES))
                    begin
                        abs_sum_next = abs_sum_reg + SUM_W'(mag);
                        count_next   = count_reg + CNT_W'(1);
                    end
                    if (last_in_frame)
                    begin
                        state_next = ST_MEAN;
                    end
                end
            end
            ST_MEAN:
            begin
                // Divider has the operands latched; clear the frame sums now
                div_start    = 1'b1;
                div_dividend = DIV_W'(abs_sum_reg);
                div_divisor  = afl_pkg::DIVISOR_W'(count_reg);
                abs_sum_next = '0;
                count_next   = '0;
                state_next   = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    if (mode_reg == afl_pkg::MODE_UNUSED)
                    begin
                        level_next = '0;
                        state_next = ST_ACCUM;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'({mean, {afl_pkg::LEVEL_SHIFT{1'b0}}});
                        div_divisor  = afl_pkg::full_scale(mode_reg);
                        state_next   = ST_LEVEL_WAIT;
                    end
                end
            end
            ST_LEVEL_WAIT:
            begin
                if (div_done)
                begin
                    level_next = div_quo[afl_pkg::LEVEL_W-1:0];
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                level_sum_next   = level_sum_reg + afl_pkg::LSUM_W'(level_reg);
                frame_count_next = frame_count_reg + afl_pkg::FCNT_W'(1);
                state_next       = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Report when the count reaches the length, or on count wrap
                if ((frame_count_reg >= frames_eff) || (frame_count_reg == '0))
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(level_sum_reg);
                    div_divisor  = afl_pkg::DIVISOR_W'(frames_eff);
                    state_next   = ST_REP_WAIT;
                end
                else
                begin
                    rep_valid_next = 1'b0;
                    rep_level_next = '0;
                    state_next     = ST_OUT;
                end
            end
            ST_REP_WAIT:
            begin
                if (div_done)
                begin
                    rep_valid_next = 1'b1;
                    // Clamp the average to 1.0
                    if (div_quo > DIV_W'(afl_pkg::LEVEL_ONE))
                    begin
                        rep_level_next = afl_pkg::LEVEL_ONE;
                    end
                    else
                    begin
                        rep_level_next = div_quo[afl_pkg::REPORT_W-1:0];
                    end
                    level_sum_next   = '0;
                    frame_count_next = '0;
                    state_next       = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Hold the result until the output register can take it
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_level_next     = level_reg;
                    out_rep_valid_next = rep_valid_reg;
                    out_rep_level_next = rep_level_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= afl_pkg::RESET_MODE;
            frames_reg      <= afl_pkg::RESET_FRAMES;
            abs_sum_reg     <= '0;
            count_reg       <= '0;
            level_sum_reg   <= '0;
            frame_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            abs_sum_reg     <= abs_sum_next;
            count_reg       <= count_next;
            level_sum_reg   <= level_sum_next;
            frame_count_reg <= frame_count_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    afl_pkg::REG_WIDTH_MODE: mode_reg   <= cfg_data[afl_pkg::MODE_W-1:0];
                    afl_pkg::REG_FRAMES:     frames_reg <= cfg_data;
                    default:                 frames_reg <= frames_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        level_reg         <= level_next;
        rep_valid_reg     <= rep_valid_next;
        rep_level_reg     <= rep_level_next;
        out_level_reg     <= out_level_next;
        out_rep_valid_reg <= out_rep_valid_next;
        out_rep_level_reg <= out_rep_level_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_level  = out_level_reg;
    assign report_valid = out_rep_valid_reg;
    assign report_level = out_rep_level_reg;

endmodule

@@ hdl/afl_mag.sv @@
`timescale 1ns / 1ps

module afl_mag
(
    input  logic [afl_pkg::SAMPLE_W-1:0] sample,
    input  logic [afl_pkg::MODE_W-1:0]   mode,
    output logic [afl_pkg::MAG_W-1:0]    magnitude
);

    logic [afl_pkg::SAMPLE_W:0] ext;
    logic [afl_pkg::SAMPLE_W:0] pos;

    // Sign-extend the low bits of the selected width to 33 bits
    always_comb
    begin
        case (mode)
            afl_pkg::MODE_8BIT:  ext = {{25{sample[7]}}, sample[7:0]};
            afl_pkg::MODE_16BIT: ext = {{17{sample[15]}}, sample[15:0]};
            default:             ext = {sample[31], sample};
        endcase
        pos = ext[afl_pkg::SAMPLE_W] ? (~ext + 33'd1) : ext;
    end

    // Most negative value gives 2^(w-1), which still fits in 32 bits
    assign magnitude = pos[afl_pkg::MAG_W-1:0];

endmodule

@@ hdl/afl_div.sv @@
`timescale 1ns / 1ps

module afl_div
#(
    parameter int DIVIDEND_W = 49
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DIVIDEND_W-1:0]          dividend,
    input  logic [afl_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [DIVIDEND_W-1:0]          quotient
);

    localparam int DW  = afl_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         dvs_reg, dvs_next;

    logic [DW:0] rem_shift;
    logic [DW:0] diff;
    logic        fits;

    // One restoring step per cycle while busy, quotient bit shifted in at the bottom
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fits      = ~diff[DW];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : rem_shift[DW-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
